/* hdl/qlcs_pkg.sv */
package qlcs_pkg;

   // field widths
   localparam int SIZE_W  = 31;
   localparam int TICK_W  = 32;
   localparam int PRICE_W = 48;
   localparam int TIME_W  = 27;
   localparam int FACT_W  = 17;
   localparam int SF_W    = 24;
   localparam int THR_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;

   localparam logic [TIME_W-1:0] MIN_STABILITY_MS = TIME_W'(20);
   localparam logic [FACT_W-1:0] FACTOR_ONE       = FACT_W'(65536);

   // request type codes
   localparam logic [1:0] REQ_QUOTE = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_INTR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DEPLETION  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_FRC = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      KIND_QUOTE,
      KIND_TICK,
      KIND_INTR
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK_G,
      S_TICK_D,
      S_WRITE,
      S_PREV,
      S_MUL_LO,
      S_MUL_HI,
      S_MARG,
      S_RD,
      S_CHK,
      S_EVAL,
      S_OUT
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic [SIZE_W-1:0]          bid_size;
      logic signed [TICK_W-1:0]   bid_tick;
      logic [SIZE_W-1:0]          ask_size;
      logic signed [TICK_W-1:0]   ask_tick;
      logic signed [PRICE_W-1:0]  bid_price;
      logic signed [PRICE_W-1:0]  ask_price;
      logic signed [PRICE_W-1:0]  weighted_price;
      logic [TIME_W-1:0]          time_ms;
      logic                       book_ready;
      logic [SIZE_W-1:0]          l1_size;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0]          stability_ms;
      logic [FACT_W-1:0]          growth_factor;
      logic [FACT_W-1:0]          depletion_factor;
      logic signed [SF_W-1:0]     stable_fraction;
   } cfg_type;

   typedef struct packed {
      logic [SIZE_W-1:0]          size;
      logic signed [TICK_W-1:0]   tick;
      logic [TIME_W-1:0]          time_ms;
   } entry_type;

endpackage

/* hdl/quote_level_change_signal.sv */
// channel   ports                          direction  handshake
// request   req_type, req_bid_size ...     in         req_valid / req_ready
// result    rsp_indicator_value            out        rsp_valid / rsp_ready
// config    csr_index, csr_data            in         csr_write, no wait
//
// a ready quote takes 1 .. RING_DEPTH trim steps in
// the window walk over the ring memories (one read port each, registered)
// period ticks, interrupts and quotes before ready skip the window walk
// a two entry request queue keeps accepting while the sequencer works, until it holds two entries
// reset clears control state; an unwritten ring entry may be read but is never used
// a waiting result sits in the output register and stalls only the sequencer
module quote_level_change_signal #(
   parameter int RING_DEPTH      = 10,
   parameter int PRICE_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [qlcs_pkg::SIZE_W-1:0]         req_bid_size,
   input  logic signed [qlcs_pkg::TICK_W-1:0]  req_bid_tick,
   input  logic [qlcs_pkg::SIZE_W-1:0]         req_ask_size,
   input  logic signed [qlcs_pkg::TICK_W-1:0]  req_ask_tick,
   input  logic signed [qlcs_pkg::PRICE_W-1:0] req_bid_price,
   input  logic signed [qlcs_pkg::PRICE_W-1:0] req_ask_price,
   input  logic signed [qlcs_pkg::PRICE_W-1:0] req_weighted_price,
   input  logic [qlcs_pkg::TIME_W-1:0]         req_time_ms,
   input  logic                                req_book_ready,
   input  logic [qlcs_pkg::SIZE_W-1:0]         req_l1_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qlcs_pkg::PRICE_W-1:0] rsp_indicator_value,
   input  logic                                csr_write,
   input  logic [qlcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qlcs_pkg::CSR_DATA_W-1:0]     csr_data
);

   qlcs_pkg::cfg_type  cfg_ff, cfg_in;
   qlcs_pkg::item_type req_item, q_item;
   logic               q_valid, q_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            qlcs_pkg::CSR_STABILITY:  cfg_in.stability_ms     = csr_data;
            qlcs_pkg::CSR_GROWTH:     cfg_in.growth_factor    = csr_data[16:0];
            qlcs_pkg::CSR_DEPLETION:  cfg_in.depletion_factor = csr_data[16:0];
            qlcs_pkg::CSR_STABLE_FRC: cfg_in.stable_fraction  = $signed(csr_data[23:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stability_ms     <= qlcs_pkg::TIME_W'(1000);
         cfg_ff.growth_factor    <= '0;
         cfg_ff.depletion_factor <= '0;
         cfg_ff.stable_fraction  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request payload bundle
   always_comb begin
      req_item.kind           = qlcs_pkg::KIND_QUOTE;
      req_item.bid_size       = req_bid_size;
      req_item.bid_tick       = req_bid_tick;
      req_item.ask_size       = req_ask_size;
      req_item.ask_tick       = req_ask_tick;
      req_item.bid_price      = req_bid_price;
      req_item.ask_price      = req_ask_price;
      req_item.weighted_price = req_weighted_price;
      req_item.time_ms        = req_time_ms;
      req_item.book_ready     = req_book_ready;
      req_item.l1_size        = req_l1_size;
   end

   qlcs_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_item(req_item), .req_type(req_type),
      .item_valid(q_valid), .item(q_item), .item_pop(q_pop)
   );

   qlcs_back #(.RING_DEPTH(RING_DEPTH), .PRICE_FRAC_BITS(PRICE_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .item_valid(q_valid), .item(q_item), .item_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_indicator_value(rsp_indicator_value)
   );

endmodule

/* hdl/qlcs_ram.sv */
module qlcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/qlcs_front.sv */
module qlcs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qlcs_pkg::item_type  req_item,
   input  logic [1:0]          req_type,
   output logic                item_valid,
   output qlcs_pkg::item_type  item,
   input  logic                item_pop
);

   qlcs_pkg::item_type entries_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   qlcs_pkg::item_type classified;

   // classify request type, unused code is dropped
   always_comb begin
      classified = req_item;
      push       = 1'b0;
      unique case (req_type)
         qlcs_pkg::REQ_QUOTE: begin
            classified.kind = qlcs_pkg::KIND_QUOTE;
            push = 1'b1;
         end
         qlcs_pkg::REQ_TICK: begin
            classified.kind = qlcs_pkg::KIND_TICK;
            push = 1'b1;
         end
         qlcs_pkg::REQ_INTR: begin
            classified.kind = qlcs_pkg::KIND_INTR;
            push = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase
      push = push && req_valid && req_ready;
   end

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entries_ff[rd_ptr_ff];

   // two entry queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("queue written while full");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (count_ff != 2'd0))
      else $error("queue popped while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
`endif

endmodule

/* hdl/qlcs_back.sv */
module qlcs_back #(
   parameter int RING_DEPTH      = 10,
   parameter int PRICE_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qlcs_pkg::cfg_type                  cfg,
   input  logic                               item_valid,
   input  qlcs_pkg::item_type                 item,
   output logic                               item_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [qlcs_pkg::PRICE_W-1:0] rsp_indicator_value
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int EW = $bits(qlcs_pkg::entry_type);
   localparam logic [IW-1:0] LAST_SLOT = IW'(RING_DEPTH - 1);
   localparam logic [60:0]   MARGIN_LIM = 61'(1) << 60;
   localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< 47) - 64'sd1;
   localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< 47);

   // control state
   qlcs_pkg::state_type state_ff, state_in;
   logic                ready_ff, ready_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic [IW-1:0]       start_b_ff, start_b_in;
   logic [IW-1:0]       start_a_ff, start_a_in;
   logic signed [qlcs_pkg::THR_W-1:0] gthr_ff, gthr_in;
   logic signed [qlcs_pkg::THR_W-1:0] dthr_ff, dthr_in;
   logic                done_b_ff, done_b_in;
   logic                done_a_ff, done_a_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   qlcs_pkg::item_type  cur_ff, cur_in;
   logic                intr_ff, intr_in;
   logic                eq_b_ff, eq_b_in;
   logic                eq_a_ff, eq_a_in;
   logic signed [qlcs_pkg::TICK_W-1:0] ts_b_ff, ts_b_in;
   logic signed [qlcs_pkg::TICK_W-1:0] ts_a_ff, ts_a_in;
   logic [55:0]         lo_ff, lo_in;
   logic [40:0]         hi_ff, hi_in;
   logic signed [61:0]  c_ff, c_in;
   logic                bid_up_ff, bid_up_in;
   logic                ask_up_ff, ask_up_in;
   logic                dep_b_ff, dep_b_in;
   logic                dep_a_ff, dep_a_in;
   logic signed [63:0]  vb_ff, vb_in;
   logic signed [63:0]  va_ff, va_in;
   logic signed [63:0]  db_ff, db_in;
   logic signed [63:0]  da_ff, da_in;
   logic signed [qlcs_pkg::PRICE_W-1:0] rsp_val_ff, rsp_val_in;

   // ring memories
   logic                wr_en;
   logic [IW-1:0]       rd_addr_b, rd_addr_a;
   logic [EW-1:0]       wr_b, wr_a, rd_b_raw, rd_a_raw;
   qlcs_pkg::entry_type rd_b, rd_a;

   // helpers
   logic [qlcs_pkg::FACT_W-1:0] eff_g, eff_d, d_pick;
   logic [qlcs_pkg::TIME_W-1:0] stab;
   logic [IW-1:0]       prev_slot;
   logic signed [48:0]  spread;
   logic                neg;
   logic [23:0]         mag_m;
   logic [48:0]         mag_s;
   logic [47:0]         mul_t;
   logic [73:0]         prod;
   logic [73:0]         shifted;
   logic [60:0]         q;
   logic                rem;
   logic signed [27:0]  age_b, age_a;
   logic                drop_b, drop_a;
   logic signed [63:0]  v_sel;

   function automatic logic [IW-1:0] inc_slot(input logic [IW-1:0] s);
      inc_slot = (s == LAST_SLOT) ? '0 : s + IW'(1);
   endfunction

   assign wr_b = {cur_ff.bid_size, cur_ff.bid_tick, cur_ff.time_ms};
   assign wr_a = {cur_ff.ask_size, cur_ff.ask_tick, cur_ff.time_ms};
   assign rd_b = qlcs_pkg::entry_type'(rd_b_raw);
   assign rd_a = qlcs_pkg::entry_type'(rd_a_raw);

   qlcs_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_bid_ring (
      .clock(clock), .wr_en(wr_en), .wr_addr(slot_ff), .wr_data(wr_b),
      .rd_addr(rd_addr_b), .rd_data(rd_b_raw)
   );

   qlcs_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_ask_ring (
      .clock(clock), .wr_en(wr_en), .wr_addr(slot_ff), .wr_data(wr_a),
      .rd_addr(rd_addr_a), .rd_data(rd_a_raw)
   );

   // effective configuration
   always_comb begin
      eff_g  = (cfg.growth_factor > qlcs_pkg::FACTOR_ONE) ? qlcs_pkg::FACTOR_ONE
                                                          : cfg.growth_factor;
      d_pick = (cfg.depletion_factor > eff_g) ? cfg.depletion_factor : eff_g;
      eff_d  = (d_pick > qlcs_pkg::FACTOR_ONE) ? qlcs_pkg::FACTOR_ONE : d_pick;
      stab   = (cfg.stability_ms < qlcs_pkg::MIN_STABILITY_MS)
               ? qlcs_pkg::MIN_STABILITY_MS : cfg.stability_ms;
   end

   // margin operands and saturation
   always_comb begin
      prev_slot = (slot_ff == '0) ? LAST_SLOT : slot_ff - IW'(1);
      spread  = 49'(cur_ff.ask_price) - 49'(cur_ff.bid_price);
      neg     = cfg.stable_fraction[qlcs_pkg::SF_W-1] ^ spread[48];
      mag_m   = cfg.stable_fraction[qlcs_pkg::SF_W-1]
                ? 24'(-cfg.stable_fraction) : 24'(cfg.stable_fraction);
      mag_s   = spread[48] ? 49'(-spread) : 49'(spread);
      prod    = {hi_ff, 32'd0} + 74'(lo_ff);
      shifted = prod >> PRICE_FRAC_BITS;
      q       = (shifted >= 74'(MARGIN_LIM)) ? MARGIN_LIM : shifted[60:0];
      rem     = (lo_ff[PRICE_FRAC_BITS-1:0] != '0);
      mul_t   = 48'(eff_g) * 48'(cur_ff.l1_size);
      age_b   = $signed({1'b0, cur_ff.time_ms}) - $signed({1'b0, rd_b.time_ms});
      age_a   = $signed({1'b0, cur_ff.time_ms}) - $signed({1'b0, rd_a.time_ms});
      drop_b  = (cur_ff.bid_tick < rd_b.tick) ||
                (cur_ff.bid_tick == rd_b.tick && cur_ff.bid_size < rd_b.size);
      drop_a  = (cur_ff.ask_tick > rd_a.tick) ||
                (cur_ff.ask_tick == rd_a.tick && cur_ff.ask_size < rd_a.size);
   end

   // result selection
   always_comb begin
      v_sel = 64'sd0;
      if (!intr_ff) begin
         if (bid_up_ff && !ask_up_ff) begin
            v_sel = (vb_ff < 64'sd0) ? 64'sd0 : vb_ff;
         end else if (ask_up_ff && !bid_up_ff) begin
            v_sel = (va_ff > 64'sd0) ? 64'sd0 : va_ff;
         end else if (!bid_up_ff && !ask_up_ff) begin
            if (dep_b_ff) begin
               v_sel = db_ff;
            end else if (dep_a_ff) begin
               v_sel = da_ff;
            end
         end
      end
      if (v_sel > OUT_MAX) begin
         v_sel = OUT_MAX;
      end else if (v_sel < OUT_MIN) begin
         v_sel = OUT_MIN;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      slot_in      = slot_ff;
      start_b_in   = start_b_ff;
      start_a_in   = start_a_ff;
      gthr_in      = gthr_ff;
      dthr_in      = dthr_ff;
      done_b_in    = done_b_ff;
      done_a_in    = done_a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cur_in       = cur_ff;
      intr_in      = intr_ff;
      eq_b_in      = eq_b_ff;
      eq_a_in      = eq_a_ff;
      ts_b_in      = ts_b_ff;
      ts_a_in      = ts_a_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      c_in         = c_ff;
      bid_up_in    = bid_up_ff;
      ask_up_in    = ask_up_ff;
      dep_b_in     = dep_b_ff;
      dep_a_in     = dep_a_ff;
      vb_in        = vb_ff;
      va_in        = va_ff;
      db_in        = db_ff;
      da_in        = da_ff;
      rsp_val_in   = rsp_val_ff;
      item_pop     = 1'b0;
      wr_en        = 1'b0;
      rd_addr_b    = start_b_ff;
      rd_addr_a    = start_a_ff;

      unique case (state_ff)
         qlcs_pkg::S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               intr_in  = 1'b0;
               unique case (item.kind)
                  qlcs_pkg::KIND_TICK: begin
                     state_in = qlcs_pkg::S_TICK_G;
                  end
                  qlcs_pkg::KIND_INTR: begin
                     intr_in  = 1'b1;
                     state_in = qlcs_pkg::S_OUT;
                  end
                  qlcs_pkg::KIND_QUOTE: begin
                     if (ready_ff) begin
                        state_in = qlcs_pkg::S_WRITE;
                     end else begin
                        ready_in = item.book_ready && (gthr_ff > 0) && (dthr_ff > 0);
                     end
                  end
                  default: begin
                     state_in = qlcs_pkg::S_IDLE;
                  end
               endcase
            end
         end
         // thresholds from l1 size, one product a cycle
         qlcs_pkg::S_TICK_G: begin
            gthr_in  = $signed(mul_t[47:16]);
            state_in = qlcs_pkg::S_TICK_D;
         end
         qlcs_pkg::S_TICK_D: begin
            dthr_in  = $signed(32'((48'(eff_d) * 48'(cur_ff.l1_size)) >> 16));
            state_in = qlcs_pkg::S_IDLE;
         end
         // store quote and fetch previous entry
         qlcs_pkg::S_WRITE: begin
            wr_en     = 1'b1;
            rd_addr_b = prev_slot;
            rd_addr_a = prev_slot;
            state_in  = qlcs_pkg::S_PREV;
         end
         // level drop cuts window back to newest entry
         qlcs_pkg::S_PREV: begin
            if (start_b_ff != slot_ff && drop_b) begin
               start_b_in = slot_ff;
            end
            if (start_a_ff != slot_ff && drop_a) begin
               start_a_in = slot_ff;
            end
            eq_b_in   = (cur_ff.bid_tick == rd_b.tick) && (cur_ff.bid_size <= rd_b.size);
            eq_a_in   = (cur_ff.ask_tick == rd_a.tick) && (cur_ff.ask_size <= rd_a.size);
            done_b_in = 1'b0;
            done_a_in = 1'b0;
            state_in  = qlcs_pkg::S_MUL_LO;
         end
         qlcs_pkg::S_MUL_LO: begin
            lo_in    = 56'(mag_m) * 56'(mag_s[31:0]);
            state_in = qlcs_pkg::S_MUL_HI;
         end
         qlcs_pkg::S_MUL_HI: begin
            hi_in    = 41'(mag_m) * 41'(mag_s[48:32]);
            state_in = qlcs_pkg::S_MARG;
         end
         qlcs_pkg::S_MARG: begin
            if (neg) begin
               c_in = -$signed({1'b0, q + 61'(rem && (q < MARGIN_LIM))});
            end else begin
               c_in = $signed({1'b0, q});
            end
            state_in = qlcs_pkg::S_RD;
         end
         qlcs_pkg::S_RD: begin
            state_in = qlcs_pkg::S_CHK;
         end
         // age trim from the old end, one entry a step
         qlcs_pkg::S_CHK: begin
            if (!done_b_ff) begin
               if (start_b_ff != slot_ff && age_b > $signed({1'b0, stab})) begin
                  start_b_in = inc_slot(start_b_ff);
               end else begin
                  done_b_in = 1'b1;
                  ts_b_in   = rd_b.tick;
               end
            end
            if (!done_a_ff) begin
               if (start_a_ff != slot_ff && age_a > $signed({1'b0, stab})) begin
                  start_a_in = inc_slot(start_a_ff);
               end else begin
                  done_a_in = 1'b1;
                  ts_a_in   = rd_a.tick;
               end
            end
            state_in = (done_b_in && done_a_in) ? qlcs_pkg::S_EVAL : qlcs_pkg::S_RD;
         end
         qlcs_pkg::S_EVAL: begin
            bid_up_in = (cur_ff.bid_tick > ts_b_ff) &&
                        (64'(cur_ff.weighted_price) - 64'(cur_ff.bid_price) < 64'(c_ff)) &&
                        ($signed({1'b0, cur_ff.bid_size}) > gthr_ff);
            ask_up_in = (cur_ff.ask_tick < ts_a_ff) &&
                        (64'(cur_ff.ask_price) - 64'(cur_ff.weighted_price) < 64'(c_ff)) &&
                        ($signed({1'b0, cur_ff.ask_size}) > gthr_ff);
            dep_b_in  = (start_b_ff != slot_ff) && eq_b_ff &&
                        ($signed({1'b0, cur_ff.bid_size}) < dthr_ff);
            dep_a_in  = (start_a_ff != slot_ff) && eq_a_ff &&
                        ($signed({1'b0, cur_ff.ask_size}) < dthr_ff);
            vb_in = 64'(cur_ff.bid_price) + 64'(c_ff) - 64'(cur_ff.weighted_price);
            va_in = 64'(cur_ff.ask_price) - 64'(c_ff) - 64'(cur_ff.weighted_price);
            db_in = 64'(cur_ff.bid_price) - 64'(cur_ff.weighted_price);
            da_in = 64'(cur_ff.ask_price) - 64'(cur_ff.weighted_price);
            state_in = qlcs_pkg::S_OUT;
         end
         // hand result to output register when free
         qlcs_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = v_sel[qlcs_pkg::PRICE_W-1:0];
               if (!intr_ff) begin
                  slot_in = inc_slot(slot_ff);
               end
               state_in = qlcs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = qlcs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qlcs_pkg::S_IDLE;
         ready_ff     <= 1'b0;
         slot_ff      <= '0;
         start_b_ff   <= '0;
         start_a_ff   <= '0;
         gthr_ff      <= -32'sd1;
         dthr_ff      <= -32'sd1;
         done_b_ff    <= 1'b0;
         done_a_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         slot_ff      <= slot_in;
         start_b_ff   <= start_b_in;
         start_a_ff   <= start_a_in;
         gthr_ff      <= gthr_in;
         dthr_ff      <= dthr_in;
         done_b_ff    <= done_b_in;
         done_a_ff    <= done_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      intr_ff    <= intr_in;
      eq_b_ff    <= eq_b_in;
      eq_a_ff    <= eq_a_in;
      ts_b_ff    <= ts_b_in;
      ts_a_ff    <= ts_a_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      c_ff       <= c_in;
      bid_up_ff  <= bid_up_in;
      ask_up_ff  <= ask_up_in;
      dep_b_ff   <= dep_b_in;
      dep_a_ff   <= dep_a_in;
      vb_ff      <= vb_in;
      va_ff      <= va_in;
      db_ff      <= db_in;
      da_ff      <= da_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_indicator_value = rsp_val_ff;

`ifndef SYNTH
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("write slot out of ring");
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      (start_b_ff <= LAST_SLOT) && (start_a_ff <= LAST_SLOT))
      else $error("window start out of ring");
   a_ready_sticks: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("ready flag dropped");
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qlcs_pkg::S_CHK && start_b_ff == slot_ff && start_a_ff == slot_ff)
      |=> (state_ff == qlcs_pkg::S_EVAL))
      else $error("trim walk passed the newest entry");
`endif

endmodule
